// File: rtl/uct_pkg.sv
`default_nettype none
package uct_pkg;

    // Format codes; a register value of 3 behaves as UTF-32
    localparam logic [1:0] FMT_UTF8  = 2'd0;
    localparam logic [1:0] FMT_UTF16 = 2'd1;
    localparam logic [1:0] FMT_UTF32 = 2'd2;

    // Result error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_LEAD  = 3'd1;
    localparam logic [2:0] ERR_SURR  = 3'd2;
    localparam logic [2:0] ERR_RANGE = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOURCE = 2'd0;
    localparam logic [1:0] CFG_TARGET = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] MAX_POINT = 32'h0010_FFFF;

    // One decoded code point or one error, handed from front to back
    typedef struct packed {
        logic [31:0] cp;
        logic [2:0]  err;
    } t_entry;

endpackage : uct_pkg
`default_nettype wire

// File: rtl/uct_front.sv
`default_nettype none
module uct_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [1:0]          i_src_fmt,
    input  wire                 i_clear,
    input  wire                 i_accept,
    input  wire  [31:0]         i_unit,
    input  wire                 i_final,
    output logic                o_push,
    output uct_pkg::t_entry     o_entry
);
    import uct_pkg::*;

    logic [20:0] r_pp, n_pp;
    logic [1:0]  r_need, n_need;
    logic        r_held, n_held;

    logic [7:0]  w_byte;
    logic [15:0] w_word;
    logic [20:0] w_shift;
    logic [1:0]  w_need_dec;
    logic        w_low_surr;
    logic        w_high_surr;

    always_comb begin
        w_byte      = i_unit[7:0];
        w_word      = i_unit[15:0];
        w_shift     = {r_pp[14:0], w_byte[5:0]};
        w_need_dec  = r_need - 2'd1;
        w_low_surr  = (w_word[15:10] == 6'b110111);
        w_high_surr = (w_word[15:10] == 6'b110110);

        n_pp       = r_pp;
        n_need     = r_need;
        n_held     = r_held;
        o_push     = 1'b0;
        o_entry.cp  = '0;
        o_entry.err = ERR_NONE;

        case (i_src_fmt)
            FMT_UTF8: begin
                if (r_need != 2'd0) begin
                    if (w_need_dec == 2'd0) begin
                        o_push     = 1'b1;
                        o_entry.cp = {11'd0, w_shift};
                        n_pp       = '0;
                        n_need     = 2'd0;
                    end else if (i_final) begin
                        o_push      = 1'b1;
                        o_entry.err = ERR_TRUNC;
                        n_pp        = '0;
                        n_need      = 2'd0;
                    end else begin
                        n_pp   = w_shift;
                        n_need = w_need_dec;
                    end
                end else if (!w_byte[7]) begin
                    o_push     = 1'b1;
                    o_entry.cp = {24'd0, w_byte};
                end else if (w_byte[7:5] == 3'b110 || w_byte[7:4] == 4'b1110
                             || w_byte[7:3] == 5'b11110) begin
                    // lead byte: open a sequence unless the text ends here
                    if (i_final) begin
                        o_push      = 1'b1;
                        o_entry.err = ERR_TRUNC;
                        n_pp        = '0;
                        n_need      = 2'd0;
                    end else if (w_byte[7:5] == 3'b110) begin
                        n_pp   = {16'd0, w_byte[4:0]};
                        n_need = 2'd1;
                    end else if (w_byte[7:4] == 4'b1110) begin
                        n_pp   = {17'd0, w_byte[3:0]};
                        n_need = 2'd2;
                    end else begin
                        n_pp   = {18'd0, w_byte[2:0]};
                        n_need = 2'd3;
                    end
                end else begin
                    o_push      = 1'b1;
                    o_entry.err = ERR_LEAD;
                    n_pp        = '0;
                    n_need      = 2'd0;
                    n_held      = 1'b0;
                end
            end
            FMT_UTF16: begin
                if (r_held) begin
                    o_push = 1'b1;
                    n_pp   = '0;
                    n_need = 2'd0;
                    n_held = 1'b0;
                    if (w_low_surr) begin
                        o_entry.cp = 32'h0001_0000 + {12'd0, r_pp[9:0], w_word[9:0]};
                    end else begin
                        o_entry.err = ERR_SURR;
                    end
                end else if (w_high_surr) begin
                    if (i_final) begin
                        o_push      = 1'b1;
                        o_entry.err = ERR_TRUNC;
                        n_pp        = '0;
                        n_need      = 2'd0;
                    end else begin
                        n_pp   = {11'd0, w_word[9:0]};
                        n_held = 1'b1;
                    end
                end else if (w_low_surr) begin
                    o_push      = 1'b1;
                    o_entry.err = ERR_SURR;
                    n_pp        = '0;
                    n_need      = 2'd0;
                end else begin
                    o_push     = 1'b1;
                    o_entry.cp = {16'd0, w_word};
                end
            end
            default: begin
                o_push     = 1'b1;
                o_entry.cp = i_unit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pp   <= '0;
            r_need <= 2'd0;
            r_held <= 1'b0;
        end else if (i_accept) begin
            r_pp   <= n_pp;
            r_need <= n_need;
            r_held <= n_held;
        end
    end

endmodule : uct_front
`default_nettype wire

// File: rtl/uct_fifo.sv
`default_nettype none
module uct_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  uct_pkg::t_entry     i_data,
    input  wire                 i_pop,
    output uct_pkg::t_entry     o_data,
    output logic                o_full,
    output logic                o_empty
);
    import uct_pkg::*;

    t_entry               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wptr;
    logic [QUEUE_AW-1:0]  r_rptr;
    logic [QUEUE_AW:0]    r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : uct_fifo
`default_nettype wire

// File: rtl/uct_back.sv
`default_nettype none
module uct_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [1:0]          i_tgt_fmt,
    input  uct_pkg::t_entry     i_entry,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [31:0]         o_unit,
    output logic                o_last,
    output logic [2:0]          o_err
);
    import uct_pkg::*;

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [31:0] r_unit;
    logic        r_last;
    logic [2:0]  r_err;

    logic [31:0] w_cp;
    logic [19:0] w_off;
    logic [2:0]  w_err;
    logic [1:0]  w_top;
    logic [31:0] w_u [4];
    logic        w_load;
    logic        w_beat_last;

    always_comb begin
        w_cp  = i_entry.cp;
        w_off = 20'(w_cp - 32'h0001_0000);
        w_err = i_entry.err;
        if (w_err == ERR_NONE) begin
            if (w_cp > MAX_POINT) begin
                w_err = ERR_RANGE;
            end else if (i_tgt_fmt == FMT_UTF16 && w_cp[31:11] == 21'h1B) begin
                w_err = ERR_RANGE;
            end
        end

        w_top  = 2'd0;
        w_u[0] = w_cp;
        w_u[1] = '0;
        w_u[2] = '0;
        w_u[3] = '0;
        case (i_tgt_fmt)
            FMT_UTF8: begin
                if (w_cp <= 32'h7F) begin
                    w_top = 2'd0;
                end else if (w_cp <= 32'h7FF) begin
                    w_top  = 2'd1;
                    w_u[0] = {24'd0, 3'b110, w_cp[10:6]};
                    w_u[1] = {24'd0, 2'b10, w_cp[5:0]};
                end else if (w_cp <= 32'hFFFF) begin
                    w_top  = 2'd2;
                    w_u[0] = {24'd0, 4'b1110, w_cp[15:12]};
                    w_u[1] = {24'd0, 2'b10, w_cp[11:6]};
                    w_u[2] = {24'd0, 2'b10, w_cp[5:0]};
                end else begin
                    w_top  = 2'd3;
                    w_u[0] = {24'd0, 5'b11110, w_cp[20:18]};
                    w_u[1] = {24'd0, 2'b10, w_cp[17:12]};
                    w_u[2] = {24'd0, 2'b10, w_cp[11:6]};
                    w_u[3] = {24'd0, 2'b10, w_cp[5:0]};
                end
            end
            FMT_UTF16: begin
                if (w_cp[31:16] != 16'd0) begin
                    w_top  = 2'd1;
                    w_u[0] = {16'd0, 6'b110110, w_off[19:10]};
                    w_u[1] = {16'd0, 6'b110111, w_off[9:0]};
                end
            end
            default: w_top = 2'd0;
        endcase
        if (w_err != ERR_NONE) begin
            w_top  = 2'd0;
            w_u[0] = '0;
        end

        w_load      = !r_valid || i_ready;
        w_beat_last = (r_idx == w_top);
        o_pop       = w_load && !i_empty && w_beat_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_unit <= w_u[r_idx];
            r_last <= w_beat_last;
            r_err  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= w_beat_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_last  = r_last;
    assign o_err   = r_err;

endmodule : uct_back
`default_nettype wire

// File: rtl/unicode_transcoder.sv
`default_nettype none
// Streaming UTF-8 / UTF-16 / UTF-32 transcoder. Each input beat carries one
// source code unit (tdata, low 8 or 16 bits used for UTF-8 / UTF-16) and
// tlast marks the last unit of the text. Multi-unit sequences are gathered
// into a code point, which leaves as one to four target units with tlast on
// the final unit; tuser carries the error code, and a bad input yields one
// beat with data zero, tlast set and a nonzero code. A decoder front end
// takes one input beat per cycle into a two-entry queue while it is not
// full; an encoder back end drains it at one output unit per cycle while
// the output side is ready. Units that only advance a sequence produce no
// output. Write the format registers only while the block is idle; a write
// also drops any partial sequence.
module unicode_transcoder (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // input stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [31:0]  i_s_tdata,   // [31:0] code_unit
    input  wire          i_s_tlast,   // final_unit
    // output stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [31:0]  o_m_tdata,   // [31:0] out_unit
    output logic         o_m_tlast,   // last_of_run
    output logic [2:0]   o_m_tuser,   // [2:0] error_code
    // configuration writes
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_idx,
    input  wire  [1:0]   i_cfg_data
);
    import uct_pkg::*;

    logic [1:0] r_src_fmt;
    logic [1:0] r_tgt_fmt;
    logic       w_clear;
    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_entry     w_in_entry;
    t_entry     w_head;

    // Any write to a defined register drops the sequence in progress
    assign w_clear  = i_cfg_we && (i_cfg_idx == CFG_SOURCE || i_cfg_idx == CFG_TARGET);
    assign o_s_tready = !w_full;
    assign w_accept = i_s_tvalid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_UTF16;
            r_tgt_fmt <= FMT_UTF8;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SOURCE) begin
                r_src_fmt <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_TARGET) begin
                r_tgt_fmt <= i_cfg_data;
            end
        end
    end

    // Decode: collect units into points, classify input errors
    uct_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src_fmt (r_src_fmt),
        .i_clear   (w_clear),
        .i_accept  (w_accept),
        .i_unit    (i_s_tdata),
        .i_final   (i_s_tlast),
        .o_push    (w_push),
        .o_entry   (w_in_entry)
    );

    // Hold decoded points so each side stalls on its own
    uct_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept && w_push),
        .i_data  (w_in_entry),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Encode: emit one target unit per beat
    uct_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tgt_fmt (r_tgt_fmt),
        .i_entry   (w_head),
        .i_empty   (w_empty),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_unit    (o_m_tdata),
        .o_last    (o_m_tlast),
        .o_err     (o_m_tuser)
    );

endmodule : unicode_transcoder
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import uct_pkg::*;

    // Register value 3 decodes as UTF-32; indexes 2 and 3 hit no register
    localparam logic [1:0] FMT_ALIAS32 = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 8;     // covers the decode -> queue -> output path
    localparam int LONG_HOLD     = 80;    // long enough to back up the two-entry queue
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [31:0] unit;
        logic        last;
        logic [2:0]  err;
    } beat_t;

    typedef enum {ROW_MODEL, ROW_QUIET, ROW_TYPED} row_kind_e;

    typedef struct {
        logic [1:0]  src;
        logic [1:0]  tgt;
        logic [31:0] unit;
        logic        fin;
        row_kind_e   kind;
        beat_t       want;
    } row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    wire         o_s_tready;
    logic [31:0] i_s_tdata;
    logic        i_s_tlast;
    wire         o_m_tvalid;
    logic        i_m_tready;
    wire  [31:0] o_m_tdata;
    wire         o_m_tlast;
    wire  [2:0]  o_m_tuser;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [1:0]  i_cfg_data;

    unicode_transcoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Transcoder state as the block should hold it
    // ------------------------------------------------------------------
    logic [1:0]  src_fmt;
    logic [1:0]  dst_fmt;
    logic [20:0] gathered_bits;   // code point so far, or high surrogate offset
    logic [1:0]  bytes_owed;      // UTF-8 continuation bytes still to come
    logic        high_half_held;

    beat_t       step_beats[$];      // beats caused by the unit just taken
    beat_t       expected_units[$];  // beats still owed by the block
    logic [32:0] burst_units[$];     // {final, unit} of the sequence being built
    row_t        plan[$];

    int  mismatches;
    int  n_in_taken;
    bit  eager_phase;
    beat_t got_beat;
    beat_t want_beat;

    function automatic void drop_sequence();
        gathered_bits  = '0;
        bytes_owed     = '0;
        high_half_held = 1'b0;
    endfunction

    function automatic void put_beat(logic [31:0] unit, logic last, logic [2:0] err);
        beat_t b;
        b.unit = unit;
        b.last = last;
        b.err  = err;
        step_beats.push_back(b);
    endfunction

    function automatic void fail_unit(logic [2:0] err);
        drop_sequence();
        put_beat(32'h0, 1'b1, err);
    endfunction

    // Emit one code point in the target format
    function automatic void encode_point(logic [31:0] cp);
        logic [31:0] off;
        off = cp - 32'h1_0000;
        if (cp > MAX_POINT) begin
            fail_unit(ERR_RANGE);
        end else if (dst_fmt == FMT_UTF8) begin
            if (cp <= 32'h7F) begin
                put_beat(cp, 1'b1, ERR_NONE);
            end else if (cp <= 32'h7FF) begin
                put_beat({24'h0, 3'b110, cp[10:6]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
            end else if (cp <= 32'hFFFF) begin
                put_beat({24'h0, 4'b1110, cp[15:12]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[11:6]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
            end else begin
                put_beat({24'h0, 5'b11110, cp[20:18]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[17:12]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[11:6]}, 1'b0, ERR_NONE);
                put_beat({24'h0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
            end
        end else if (dst_fmt == FMT_UTF16) begin
            if (cp >= 32'hD800 && cp <= 32'hDFFF) begin
                fail_unit(ERR_RANGE);
            end else if (cp < 32'h1_0000) begin
                put_beat(cp, 1'b1, ERR_NONE);
            end else begin
                put_beat(32'hD800 + {22'h0, off[19:10]}, 1'b0, ERR_NONE);
                put_beat(32'hDC00 + {22'h0, off[9:0]}, 1'b1, ERR_NONE);
            end
        end else begin
            put_beat(cp, 1'b1, ERR_NONE);
        end
    endfunction

    // Advance the decoder by one source unit; fills step_beats
    function automatic void decode_unit(logic [31:0] unit, logic fin);
        logic [7:0]  b;
        logic [15:0] w;
        logic [9:0]  hi;
        logic [31:0] cp;
        step_beats.delete();
        b = unit[7:0];
        w = unit[15:0];
        if (src_fmt == FMT_UTF8) begin
            if (bytes_owed != 2'd0) begin
                gathered_bits = {gathered_bits[14:0], b[5:0]};
                bytes_owed    = bytes_owed - 2'd1;
                if (bytes_owed == 2'd0) begin
                    cp = {11'h0, gathered_bits};
                    drop_sequence();
                    encode_point(cp);
                    return;
                end
            end else if (b < 8'h80) begin
                encode_point({24'h0, b});
                return;
            end else if (b[7:5] == 3'b110) begin
                gathered_bits = {16'h0, b[4:0]};
                bytes_owed    = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                gathered_bits = {17'h0, b[3:0]};
                bytes_owed    = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                gathered_bits = {18'h0, b[2:0]};
                bytes_owed    = 2'd3;
            end else begin
                fail_unit(ERR_LEAD);
                return;
            end
            if (fin)
                fail_unit(ERR_TRUNC);
        end else if (src_fmt == FMT_UTF16) begin
            if (high_half_held) begin
                hi = gathered_bits[9:0];
                drop_sequence();
                if (w >= 16'hDC00 && w <= 16'hDFFF)
                    encode_point({12'h0, hi, w[9:0]} + 32'h1_0000);
                else
                    fail_unit(ERR_SURR);
            end else if (w >= 16'hD800 && w <= 16'hDBFF) begin
                if (fin) begin
                    fail_unit(ERR_TRUNC);
                end else begin
                    gathered_bits  = {11'h0, w[9:0]};
                    high_half_held = 1'b1;
                end
            end else if (w >= 16'hDC00 && w <= 16'hDFFF) begin
                fail_unit(ERR_SURR);
            end else begin
                encode_point({16'h0, w});
            end
        end else begin
            encode_point(unit);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random source text
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            case ($urandom_range(0, 9))
                0: return 32'h0;
                1: return 32'h7F;
                2: return 32'h80;
                3: return 32'h7FF;
                4: return 32'h800;
                5: return 32'hD7FF;
                6: return 32'hE000;
                7: return 32'hFFFF;
                8: return 32'h1_0000;
                default: return MAX_POINT;
            endcase
        end
        if (r < 30) return $urandom_range(0, 32'h7F);
        if (r < 48) return $urandom_range(32'h80, 32'h7FF);
        if (r < 68) return $urandom_range(32'h800, 32'hFFFF);
        if (r < 84) return $urandom_range(32'h1_0000, MAX_POINT);
        if (r < 92) return $urandom_range(32'hD800, 32'hDFFF);
        return $urandom_range(32'h11_0000, 32'h1F_FFFF);
    endfunction

    // Queue one unit; half the time junk fills the bits the format ignores
    function automatic void add_unit(logic [31:0] low, int width);
        logic [31:0] unit;
        unit = low;
        if (width < 32 && $urandom_range(0, 1) == 1)
            unit = low | ($urandom << width);
        burst_units.push_back({($urandom_range(0, 99) < 3) ? 1'b1 : 1'b0, unit});
    endfunction

    // One well-formed sequence for the current source format, sometimes
    // overlong, bent or cut short; one time in ten a raw noise unit instead
    function automatic void build_sequence();
        logic [31:0] cp;
        logic [31:0] off;
        logic [7:0]  b;
        int          len;
        burst_units.delete();
        if ($urandom_range(0, 9) == 0) begin
            add_unit($urandom, 32);
            return;
        end
        cp  = pick_point();
        off = cp - 32'h1_0000;
        if (src_fmt == FMT_UTF8) begin
            len = (cp <= 32'h7F) ? 1 : (cp <= 32'h7FF) ? 2 : (cp <= 32'hFFFF) ? 3 : 4;
            if (len < 4 && $urandom_range(0, 9) == 0)
                len++;
            case (len)
                1: b = cp[7:0];
                2: b = {3'b110, cp[10:6]};
                3: b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
            add_unit({24'h0, b}, 8);
            for (int j = len - 2; j >= 0; j--) begin
                b = 8'h80 | 8'((cp >> (6 * j)) & 32'h3F);
                if ($urandom_range(0, 9) == 0)
                    b[7:6] = 2'($urandom_range(0, 3));
                add_unit({24'h0, b}, 8);
            end
        end else if (src_fmt == FMT_UTF16) begin
            if (cp >= 32'h1_0000 && cp <= MAX_POINT) begin
                add_unit(32'hD800 + {22'h0, off[19:10]}, 16);
                add_unit(32'hDC00 + {22'h0, off[9:0]}, 16);
            end else begin
                add_unit({16'h0, cp[15:0]}, 16);
            end
        end else begin
            add_unit(cp, 32);
        end
        if (burst_units.size() > 1 && $urandom_range(0, 19) == 0)
            void'(burst_units.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------
    // Offer one beat, wait for the handshake, then book what it causes
    task automatic send_unit(input logic [31:0] unit, input logic fin,
                             input row_kind_e kind, input beat_t want);
        int gap;
        gap = eager_phase ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = unit;
        i_s_tlast  = fin;
        do @(posedge i_clk); while (!o_s_tready);
        decode_unit(unit, fin);
        case (kind)
            ROW_MODEL: begin
                foreach (step_beats[k])
                    expected_units.push_back(step_beats[k]);
            end
            ROW_TYPED: expected_units.push_back(want);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Hold the input off until every owed beat is out, then let a
    // unit that caused nothing clear the pipe as well
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (expected_units.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Caller lowers the write enable after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        if (idx == CFG_SOURCE) begin
            src_fmt = data;
            drop_sequence();
        end else if (idx == CFG_TARGET) begin
            dst_fmt = data;
            drop_sequence();
        end
    endtask

    function automatic void add_row(logic [1:0] src, logic [1:0] tgt, logic [31:0] unit,
                                    logic fin, row_kind_e kind, logic [31:0] want_unit,
                                    logic [2:0] want_err);
        row_t r;
        r.src       = src;
        r.tgt       = tgt;
        r.unit      = unit;
        r.fin       = fin;
        r.kind      = kind;
        r.want.unit = want_unit;
        r.want.last = 1'b1;
        r.want.err  = want_err;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Output check: every accepted beat against the oldest booked one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            n_in_taken <= n_in_taken + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_beat.unit = o_m_tdata;
            got_beat.last = o_m_tlast;
            got_beat.err  = o_m_tuser;
            if (expected_units.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat unit %h last %b err %0d", $realtime,
                             got_beat.unit, got_beat.last, got_beat.err);
            end else begin
                want_beat = expected_units.pop_front();
                if (got_beat.unit !== want_beat.unit || got_beat.last !== want_beat.last ||
                    got_beat.err !== want_beat.err) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected unit %h last %b err %0d, got %h %b %0d",
                                 $realtime, want_beat.unit, want_beat.last, want_beat.err,
                                 got_beat.unit, got_beat.last, got_beat.err);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready runs and random stalls; twice in the random part
    // a long hold-off while the sender keeps offering units
    // ------------------------------------------------------------------
    initial begin
        int hold_stage;
        int gap;
        hold_stage = 0;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if ((hold_stage == 0 && n_in_taken >= 120) ||
                (hold_stage == 1 && n_in_taken >= 260)) begin
                i_m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_stage++;
            end
            i_m_tready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
            gap = pick_gap();
            if (gap != 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    // Slowest legal run stays well under a tenth of this
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int    n_random;
        int    phase_len;
        int    sent_here;
        beat_t no_beat;
        no_beat     = '0;
        mismatches  = 0;
        n_in_taken  = 0;
        eager_phase = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        src_fmt     = FMT_UTF16;
        dst_fmt     = FMT_UTF8;
        drop_sequence();

        // Reset formats first: UTF-16 in, UTF-8 out
        add_row(FMT_UTF16, FMT_UTF8, 32'h0000_0041, 1'b0, ROW_TYPED, 32'h41, ERR_NONE);
        add_row(FMT_UTF16, FMT_UTF8, 32'hFFFF_DC00, 1'b0, ROW_TYPED, 32'h0, ERR_SURR);
        add_row(FMT_UTF16, FMT_UTF8, 32'h1234_D83D, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF16, FMT_UTF8, 32'h0000_DE00, 1'b0, ROW_MODEL, 32'h0, ERR_NONE);
        add_row(FMT_UTF16, FMT_UTF8, 32'h0000_D800, 1'b1, ROW_TYPED, 32'h0, ERR_TRUNC);
        // high surrogate followed by a plain word: both dropped
        add_row(FMT_UTF16, FMT_UTF8, 32'h0000_DBFF, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF16, FMT_UTF8, 32'h0000_0041, 1'b0, ROW_TYPED, 32'h0, ERR_SURR);
        add_row(FMT_UTF16, FMT_UTF8, 32'hABCD_FFFF, 1'b1, ROW_MODEL, 32'h0, ERR_NONE);
        // UTF-8 in, UTF-16 out; continuation prefix is not checked
        add_row(FMT_UTF8, FMT_UTF16, 32'hFFFF_FFC3, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0029, 1'b0, ROW_MODEL, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0080, 1'b0, ROW_TYPED, 32'h0, ERR_LEAD);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_00FF, 1'b0, ROW_TYPED, 32'h0, ERR_LEAD);
        // four-byte form beyond the last code point
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_00F4, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0090, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0080, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0080, 1'b0, ROW_TYPED, 32'h0, ERR_RANGE);
        // encoded surrogate cannot go out as UTF-16
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_00ED, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_00A0, 1'b0, ROW_QUIET, 32'h0, ERR_NONE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_0080, 1'b0, ROW_TYPED, 32'h0, ERR_RANGE);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_00E2, 1'b1, ROW_TYPED, 32'h0, ERR_TRUNC);
        add_row(FMT_UTF8, FMT_UTF16, 32'h0000_007F, 1'b0, ROW_TYPED, 32'h7F, ERR_NONE);
        // format value three behaves as UTF-32
        add_row(FMT_ALIAS32, FMT_UTF16, MAX_POINT, 1'b0, ROW_MODEL, 32'h0, ERR_NONE);
        add_row(FMT_ALIAS32, FMT_UTF16, 32'hFFFF_FFFF, 1'b0, ROW_TYPED, 32'h0, ERR_RANGE);
        add_row(FMT_UTF32, FMT_ALIAS32, 32'h0000_D800, 1'b0, ROW_TYPED, 32'hD800, ERR_NONE);
        add_row(FMT_UTF32, FMT_ALIAS32, MAX_POINT, 1'b1, ROW_TYPED, MAX_POINT, ERR_NONE);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].src != src_fmt || plan[i].tgt != dst_fmt) begin
                settle();
                write_reg(CFG_SOURCE, plan[i].src);
                write_reg(CFG_TARGET, plan[i].tgt);
                write_reg(CFG_SPARE_A, 2'($urandom_range(0, 3)));
                i_cfg_we = 1'b0;
            end
            send_unit(plan[i].unit, plan[i].fin, plan[i].kind, plan[i].want);
        end

        // Random phases: each starts idle with a fresh mix of register writes.
        // A spare-index write alone must leave a pending sequence intact.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_SOURCE, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) != 0)
                write_reg(CFG_TARGET, 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_SPARE_B, 2'($urandom_range(0, 3)));
            i_cfg_we    = 1'b0;
            eager_phase = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(10, 45);
            sent_here   = 0;
            while (sent_here < phase_len) begin
                build_sequence();
                foreach (burst_units[k])
                    send_unit(burst_units[k][31:0], burst_units[k][32], ROW_MODEL, no_beat);
                sent_here += burst_units.size();
            end
            n_random += sent_here;
        end

        settle();
        if (mismatches == 0 && expected_units.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
